[hdl/cbl_pkg.sv]
`default_nettype none

package cbl_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int INDEX_BITS_DEF = 24;

    // Operation codes carried by the mode field.
    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_APPEND = 3'd1;
    localparam logic [2:0] MODE_QUERY  = 3'd2;
    localparam logic [2:0] MODE_INSERT = 3'd3;
    localparam logic [2:0] MODE_ERASE  = 3'd4;
    localparam logic [2:0] MODE_SPLIT  = 3'd5;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_STOP_MISS = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_NBR,
        S_COPY,
        S_SPLIT_SCAN,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT,
        S_RESP,
        S_WAIT
    } state_t;

endpackage

`default_nettype wire

[hdl/cbl_mem.sv]
`default_nettype none

module cbl_mem
    import cbl_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int WIDTH = INDEX_BITS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= ram[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/cbl_seq.sv]
`default_nettype none

module cbl_seq
    import cbl_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [2:0]            mode,
    input  wire logic [INDEX_BITS-1:0] point,
    input  wire logic [INDEX_BITS-1:0] anchor,
    input  wire logic [INDEX_BITS-1:0] stop_point,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [1:0]            status,
    output logic                       found,
    output logic      [INDEX_BITS-1:0] prev_point,
    output logic      [INDEX_BITS-1:0] next_point,
    output logic      [CW-1:0]         count,
    output logic      [INDEX_BITS-1:0] removed_point,
    output logic                       removed_valid,
    output logic                       last,
    output logic                       mem_we,
    output logic      [AW-1:0]         mem_waddr,
    output logic      [INDEX_BITS-1:0] mem_wdata,
    output logic                       mem_re,
    output logic      [AW-1:0]         mem_raddr,
    input  wire logic [INDEX_BITS-1:0] mem_rdata
);

    state_t                  state_reg, state_next;
    logic [2:0]              mode_reg, mode_next;
    logic [INDEX_BITS-1:0]   point_reg, point_next;
    logic [INDEX_BITS-1:0]   key_reg, key_next;
    logic [INDEX_BITS-1:0]   stop_reg, stop_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [CW-1:0]           fin_reg, fin_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           num_reg, num_next;
    logic [CW-1:0]           rem_reg, rem_next;
    logic [CW-1:0]           len_reg, len_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic [AW-1:0]           src_reg, src_next;
    logic [AW-1:0]           dst_reg, dst_next;
    logic [AW-1:0]           cur_reg, cur_next;
    logic                    step_dn_reg, step_dn_next;
    logic [1:0]              status_reg, status_next;

    logic                    rd_vld_reg;
    state_t                  rd_tag_reg;
    logic [AW-1:0]           rd_idx_reg;

    logic                    out_vld_reg, out_vld_next;
    logic [1:0]              out_status_reg, out_status_next;
    logic                    out_found_reg, out_found_next;
    logic [INDEX_BITS-1:0]   out_prev_reg, out_prev_next;
    logic [INDEX_BITS-1:0]   out_nxt_reg, out_nxt_next;
    logic [CW-1:0]           out_count_reg, out_count_next;
    logic [INDEX_BITS-1:0]   out_rem_reg, out_rem_next;
    logic                    out_rvalid_reg, out_rvalid_next;
    logic                    out_last_reg, out_last_next;

    logic [AW-1:0]           last_idx;
    logic [INDEX_BITS-1:0]   cmp_key;
    logic                    cmp_eq;
    logic                    rd_hit;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a,
                                               input logic [AW-1:0] lim);
        wrap_inc = (a == lim) ? '0 : AW'(a + AW'(1));
    endfunction

    // The single comparator is shared by the key search and the stop search.
    assign last_idx = AW'(cnt_reg - CW'(1));
    assign cmp_key  = (state_reg == S_SPLIT_SCAN) ? stop_reg : key_reg;
    assign cmp_eq   = (mem_rdata == cmp_key);
    assign rd_hit   = rd_vld_reg && (rd_tag_reg == state_reg);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        logic [CW:0]   end_pos;
        logic [CW-1:0] split_r;
        logic          split_done;

        end_pos         = '0;
        split_r         = '0;
        split_done      = 1'b0;

        state_next      = state_reg;
        mode_next       = mode_reg;
        point_next      = point_reg;
        key_next        = key_reg;
        stop_next       = stop_reg;
        cnt_next        = cnt_reg;
        fin_next        = fin_reg;
        idx_next        = idx_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        len_next        = len_reg;
        pos_next        = pos_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        cur_next        = cur_reg;
        step_dn_next    = step_dn_reg;
        status_next     = status_reg;
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_prev_next   = out_prev_reg;
        out_nxt_next    = out_nxt_reg;
        out_count_next  = out_count_reg;
        out_rem_next    = out_rem_reg;
        out_rvalid_next = out_rvalid_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = mode;
                    point_next      = point;
                    key_next        = ((mode == MODE_QUERY) || (mode == MODE_ERASE))
                                      ? point : anchor;
                    stop_next       = stop_point;
                    status_next     = STAT_OK;
                    fin_next        = cnt_reg;
                    idx_next        = '0;
                    num_next        = '0;
                    out_found_next  = 1'b0;
                    out_prev_next   = '0;
                    out_nxt_next    = '0;
                    out_rem_next    = '0;
                    out_rvalid_next = 1'b0;
                    state_next      = S_RESP;
                    unique case (mode) inside
                        MODE_CLEAR:
                        begin
                            cnt_next = '0;
                            fin_next = '0;
                        end
                        MODE_APPEND:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(cnt_reg);
                                mem_wdata = point;
                                cnt_next  = cnt_reg + CW'(1);
                                fin_next  = cnt_reg + CW'(1);
                            end
                        end
                        MODE_QUERY, MODE_ERASE, MODE_SPLIT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (cnt_reg == CW'(CAPACITY))
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (cnt_reg == '0)
                            begin
                                status_next = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Reads stream one per cycle; each compare sees the read before.
                if (idx_reg < cnt_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(idx_reg);
                    idx_next  = idx_reg + CW'(1);
                end
                if (rd_hit)
                begin
                    if (cmp_eq)
                    begin
                        pos_next = rd_idx_reg;
                        idx_next = '0;
                        num_next = '0;
                        case (mode_reg)
                            MODE_QUERY:
                            begin
                                out_found_next = 1'b1;
                                state_next     = S_NBR;
                            end
                            MODE_INSERT:
                            begin
                                src_next     = last_idx;
                                dst_next     = AW'(cnt_reg);
                                step_dn_next = 1'b1;
                                len_next     = cnt_reg - CW'(rd_idx_reg);
                                fin_next     = cnt_reg + CW'(1);
                                state_next   = S_COPY;
                            end
                            MODE_ERASE:
                            begin
                                src_next     = AW'(rd_idx_reg + AW'(1));
                                dst_next     = rd_idx_reg;
                                step_dn_next = 1'b0;
                                len_next     = cnt_reg - CW'(rd_idx_reg) - CW'(1);
                                fin_next     = cnt_reg - CW'(1);
                                state_next   = S_COPY;
                            end
                            MODE_SPLIT:
                            begin
                                cur_next   = wrap_inc(rd_idx_reg, last_idx);
                                state_next = S_SPLIT_SCAN;
                            end
                            default:
                            begin
                                state_next = S_RESP;
                            end
                        endcase
                    end
                    else if (rd_idx_reg == last_idx)
                    begin
                        status_next = STAT_NOT_FOUND;
                        state_next  = S_RESP;
                    end
                end
            end

            S_NBR:
            begin
                if (idx_reg == CW'(0))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = (pos_reg == '0) ? last_idx : AW'(pos_reg - AW'(1));
                    idx_next  = CW'(1);
                end
                else if (idx_reg == CW'(1))
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = wrap_inc(pos_reg, last_idx);
                    out_prev_next = mem_rdata;
                    idx_next      = CW'(2);
                end
                else
                begin
                    out_nxt_next = mem_rdata;
                    state_next   = S_RESP;
                end
            end

            S_COPY:
            begin
                // Read at src, write the returned word at dst in the following cycle.
                if (idx_reg < len_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = src_reg;
                    src_next  = step_dn_reg ? AW'(src_reg - AW'(1)) : AW'(src_reg + AW'(1));
                    idx_next  = idx_reg + CW'(1);
                end
                if (rd_hit)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = dst_reg;
                    mem_wdata = mem_rdata;
                    dst_next  = step_dn_reg ? AW'(dst_reg - AW'(1)) : AW'(dst_reg + AW'(1));
                    num_next  = num_reg + CW'(1);
                end
                else if (num_reg == len_reg)
                begin
                    cnt_next = fin_reg;
                    if (mode_reg == MODE_INSERT)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_reg;
                        mem_wdata = point_reg;
                    end
                    state_next = (mode_reg == MODE_SPLIT) ? S_IDLE : S_RESP;
                end
            end

            S_SPLIT_SCAN:
            begin
                if (idx_reg < cnt_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = cur_reg;
                    cur_next  = wrap_inc(cur_reg, last_idx);
                    idx_next  = idx_reg + CW'(1);
                end
                if (rd_hit)
                begin
                    if (cmp_eq)
                    begin
                        split_r    = num_reg;
                        split_done = 1'b1;
                    end
                    else if ((num_reg + CW'(1)) == cnt_reg)
                    begin
                        split_r     = cnt_reg;
                        split_done  = 1'b1;
                        status_next = STAT_STOP_MISS;
                    end
                    else
                    begin
                        num_next = num_reg + CW'(1);
                    end
                end
                if (split_done)
                begin
                    rem_next     = split_r;
                    fin_next     = cnt_reg - split_r;
                    step_dn_next = 1'b0;
                    // The removed run either ends before the list end or wraps to
                    // the front; in both cases the survivors slide down in order.
                    end_pos = (CW+1)'(pos_reg) + (CW+1)'(split_r) + (CW+1)'(1);
                    if (end_pos <= (CW+1)'(cnt_reg))
                    begin
                        src_next = AW'(end_pos);
                        dst_next = AW'(pos_reg + AW'(1));
                        len_next = CW'((CW+1)'(cnt_reg) - end_pos);
                    end
                    else
                    begin
                        src_next = AW'(end_pos - (CW+1)'(cnt_reg));
                        dst_next = '0;
                        len_next = cnt_reg - split_r;
                    end
                    cur_next   = wrap_inc(pos_reg, last_idx);
                    idx_next   = '0;
                    num_next   = '0;
                    state_next = (split_r == '0) ? S_RESP : S_EMIT_RD;
                end
            end

            S_EMIT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cur_reg;
                cur_next   = wrap_inc(cur_reg, last_idx);
                state_next = S_EMIT_LD;
            end

            S_EMIT_LD:
            begin
                out_rem_next    = mem_rdata;
                out_rvalid_next = 1'b1;
                out_status_next = status_reg;
                out_count_next  = fin_reg;
                out_last_next   = ((idx_reg + CW'(1)) == rem_reg);
                out_vld_next    = 1'b1;
                idx_next        = idx_reg + CW'(1);
                state_next      = S_EMIT_WAIT;
            end

            S_EMIT_WAIT:
            begin
                if (!out_stall)
                begin
                    out_vld_next = 1'b0;
                    if (idx_reg == rem_reg)
                    begin
                        idx_next   = '0;
                        num_next   = '0;
                        state_next = S_COPY;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_RESP:
            begin
                out_status_next = status_reg;
                out_count_next  = fin_reg;
                out_last_next   = 1'b1;
                out_vld_next    = 1'b1;
                state_next      = S_WAIT;
            end

            S_WAIT:
            begin
                if (!out_stall)
                begin
                    out_vld_next = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
            rd_vld_reg  <= mem_re;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        point_reg      <= point_next;
        key_reg        <= key_next;
        stop_reg       <= stop_next;
        fin_reg        <= fin_next;
        idx_reg        <= idx_next;
        num_reg        <= num_next;
        rem_reg        <= rem_next;
        len_reg        <= len_next;
        pos_reg        <= pos_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        cur_reg        <= cur_next;
        step_dn_reg    <= step_dn_next;
        status_reg     <= status_next;
        rd_tag_reg     <= state_reg;
        rd_idx_reg     <= mem_raddr;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_prev_reg   <= out_prev_next;
        out_nxt_reg    <= out_nxt_next;
        out_count_reg  <= out_count_next;
        out_rem_reg    <= out_rem_next;
        out_rvalid_reg <= out_rvalid_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid     = out_vld_reg;
    assign status        = out_status_reg;
    assign found         = out_found_reg;
    assign prev_point    = out_prev_reg;
    assign next_point    = out_nxt_reg;
    assign count         = out_count_reg;
    assign removed_point = out_rem_reg;
    assign removed_valid = out_rvalid_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire

[hdl/cyclic_boundary_list.sv]
// Cyclic boundary list: keeps up to CAPACITY point indices as a ring and serves one
// command at a time (clear, append, query, insert before an anchor, erase, split).
// Entries sit in a single-port-write, registered-read RAM that a small sequencer walks
// one word per cycle while it searches or copies, with one shared comparator for all
// searches. A query searches for the point and then reads the neighbors of its match;
// insert and erase search and then shift the tail of the list by one place; split
// searches the anchor and then the stop entry, emits each removed index as its own
// result, then compacts the survivors one per cycle. Input is stalled for the whole
// command, and each result waits in the output register until the far side takes the
// transfer. There is no clearing pass after reset.
`default_nettype none

module cyclic_boundary_list
    import cbl_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [2:0]            mode,
    input  wire logic [INDEX_BITS-1:0] point,
    input  wire logic [INDEX_BITS-1:0] anchor,
    input  wire logic [INDEX_BITS-1:0] stop_point,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic      [1:0]            status,
    output logic                       found,
    output logic      [INDEX_BITS-1:0] prev_point,
    output logic      [INDEX_BITS-1:0] next_point,
    output logic      [CW-1:0]         count,
    output logic      [INDEX_BITS-1:0] removed_point,
    output logic                       removed_valid,
    output logic                       last
);

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [INDEX_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [INDEX_BITS-1:0] mem_rdata;

    cbl_seq #(
        .CAPACITY   (CAPACITY),
        .INDEX_BITS (INDEX_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .point         (point),
        .anchor        (anchor),
        .stop_point    (stop_point),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found         (found),
        .prev_point    (prev_point),
        .next_point    (next_point),
        .count         (count),
        .removed_point (removed_point),
        .removed_valid (removed_valid),
        .last          (last),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    cbl_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (INDEX_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

[hdl/cbl_checker.sv]
`default_nettype none

module cbl_checker
    import cbl_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    localparam int CW = $clog2(CAPACITY + 1)
)
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [1:0]            status,
    input wire logic                  found,
    input wire logic [CW-1:0]         count,
    input wire logic [INDEX_BITS-1:0] removed_point,
    input wire logic                  removed_valid,
    input wire logic                  last
);

    // A stalled result holds until the transfer completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(count)
            && $stable(removed_point) && $stable(last))
        else $error("result changed while stalled");

    // No new command is taken while a result is still pending.
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input ready with a result pending");

    // In the cycle after any accepted command, the input is stalled.
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a transfer");

    // Removed entries come only from a split, never with a query hit.
    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && removed_valid |-> !found
            && (status == STAT_OK || status == STAT_STOP_MISS))
        else $error("removed entry with wrong status");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= CW'(CAPACITY))
        else $error("count above capacity");

endmodule

bind cyclic_boundary_list cbl_checker #(
    .CAPACITY   (CAPACITY),
    .INDEX_BITS (INDEX_BITS)
) u_checker (.*);

`default_nettype wire

[tb/cyclic_boundary_list_test.sv]
module cyclic_boundary_list_test
    import cbl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = CAPACITY_DEF;
    localparam int IW = INDEX_BITS_DEF;
    localparam int CW = $clog2(CAP + 1);
    localparam int RANDOM_ITEMS = 380;
    localparam int DEAD_LIMIT = 5000;
    localparam int TAIL_CYCLES = 200;

    // Mode codes that the block does not use.
    localparam logic [2:0] MODE_SPARE_A = 3'd6;
    localparam logic [2:0] MODE_SPARE_B = 3'd7;

    typedef struct packed {
        logic [1:0]    status;
        logic          found;
        logic [IW-1:0] prev_pt;
        logic [IW-1:0] next_pt;
        logic [CW-1:0] cnt;
        logic [IW-1:0] gone_pt;
        logic          gone_valid;
        logic          last_mark;
    } result_t;

    typedef struct {
        logic [2:0]    m;
        logic [IW-1:0] p;
        logic [IW-1:0] a;
        logic [IW-1:0] s;
        bit            typed;
        logic [1:0]    st;
        logic          fnd;
        logic [IW-1:0] pv;
        logic [IW-1:0] nx;
        logic [CW-1:0] cnt;
    } plan_row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic [2:0]    mode = MODE_CLEAR;
    logic [IW-1:0] point = '0;
    logic [IW-1:0] anchor = '0;
    logic [IW-1:0] stop_point = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [1:0]    status;
    logic          found;
    logic [IW-1:0] prev_point;
    logic [IW-1:0] next_point;
    logic [CW-1:0] count;
    logic [IW-1:0] removed_point;
    logic          removed_valid;
    logic          last;

    // Mirror of the ring held by the block.
    logic [IW-1:0] ring [CAP];
    int            ring_len = 0;

    result_t       step_results [$];
    result_t       due_results [$];
    plan_row_t     plan [$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  commands_sent = 0;
    int  work_items = 0;
    int  removed_total = 0;
    int  status_hits [4] = '{0, 0, 0, 0};
    int  dead_cycles = 0;
    int  rx_hold = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;

    cyclic_boundary_list dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .point(point),
        .anchor(anchor),
        .stop_point(stop_point),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .found(found),
        .prev_point(prev_point),
        .next_point(next_point),
        .count(count),
        .removed_point(removed_point),
        .removed_valid(removed_valid),
        .last(last)
    );

    always #2ns clk = ~clk;

    function automatic int locate(logic [IW-1:0] v);
        for (int i = 0; i < ring_len; i++)
            if (ring[i] == v)
                return i;
        return -1;
    endfunction

    function automatic void drop_at(int pos);
        for (int i = pos; i + 1 < ring_len; i++)
            ring[i] = ring[i + 1];
        ring_len--;
    endfunction

    // Applies one command to the ring and leaves its results in step_results.
    function automatic void apply_to_ring(logic [2:0] m, logic [IW-1:0] p, logic [IW-1:0] a,
                                          logic [IW-1:0] s);
        int            pos;
        int            cur;
        logic [1:0]    st;
        result_t       r;
        logic [IW-1:0] gone [$];
        st = STAT_OK;
        r = '0;
        step_results = {};
        case (m)
            MODE_CLEAR:
                ring_len = 0;
            MODE_APPEND:
                if (ring_len >= CAP)
                    st = STAT_FULL;
                else
                begin
                    ring[ring_len] = p;
                    ring_len++;
                end
            MODE_QUERY:
            begin
                pos = locate(p);
                if (pos < 0)
                    st = STAT_NOT_FOUND;
                else
                begin
                    r.found = 1'b1;
                    r.prev_pt = (pos == 0) ? ring[ring_len - 1] : ring[pos - 1];
                    r.next_pt = (pos + 1 == ring_len) ? ring[0] : ring[pos + 1];
                end
            end
            MODE_INSERT:
                if (ring_len >= CAP)
                    st = STAT_FULL;
                else
                begin
                    pos = locate(a);
                    if (pos < 0)
                        st = STAT_NOT_FOUND;
                    else
                    begin
                        for (int i = ring_len; i > pos; i--)
                            ring[i] = ring[i - 1];
                        ring[pos] = p;
                        ring_len++;
                    end
                end
            MODE_ERASE:
            begin
                pos = locate(p);
                if (pos < 0)
                    st = STAT_NOT_FOUND;
                else
                    drop_at(pos);
            end
            MODE_SPLIT:
            begin
                pos = locate(a);
                if (pos < 0)
                    st = STAT_NOT_FOUND;
                else
                begin
                    cur = pos + 1;
                    if (cur >= ring_len)
                        cur = 0;
                    // Walk forward around the ring; a missing stop point empties it.
                    while (1)
                    begin
                        if (ring_len == 0)
                        begin
                            st = STAT_STOP_MISS;
                            break;
                        end
                        if (ring[cur] == s)
                            break;
                        gone = {gone, ring[cur]};
                        drop_at(cur);
                        if (cur >= ring_len)
                            cur = 0;
                    end
                end
            end
            default:
                ;
        endcase
        status_hits[st]++;
        removed_total += gone.size();
        if (gone.size() == 0)
        begin
            r.status = st;
            r.cnt = CW'(ring_len);
            r.last_mark = 1'b1;
            step_results = {step_results, r};
        end
        else
            foreach (gone[i])
            begin
                r = '0;
                r.status = st;
                r.cnt = CW'(ring_len);
                r.gone_pt = gone[i];
                r.gone_valid = 1'b1;
                r.last_mark = (i + 1 == gone.size());
                step_results = {step_results, r};
            end
    endfunction

    function automatic void plan_row(logic [2:0] m, logic [IW-1:0] p, logic [IW-1:0] a,
                                     logic [IW-1:0] s, bit typed = 1'b0,
                                     logic [1:0] st = STAT_OK, logic fnd = 1'b0,
                                     logic [IW-1:0] pv = '0, logic [IW-1:0] nx = '0,
                                     logic [CW-1:0] cnt = '0);
        plan_row_t row;
        row = '{m, p, a, s, typed, st, fnd, pv, nx, cnt};
        plan = {plan, row};
    endfunction

    // Entries already in the ring with a chance of hit_pct percent, else small values, extremes or any index.
    function automatic logic [IW-1:0] pick_point(int hit_pct);
        int roll;
        roll = $urandom_range(99);
        if (ring_len > 0 && roll < hit_pct)
            return ring[$urandom_range(ring_len - 1)];
        roll = $urandom_range(9);
        if (roll < 4)
            return IW'($urandom_range(15));
        if (roll == 4)
            return ($urandom_range(1) != 0) ? {IW{1'b1}} : '0;
        return IW'($urandom());
    endfunction

    function automatic logic [IW-1:0] absent_point();
        logic [IW-1:0] v;
        do
            v = IW'($urandom());
        while (locate(v) >= 0);
        return v;
    endfunction

    function automatic int tx_gap();
        int roll;
        roll = $urandom_range(99);
        if (tx_steady || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_command(input logic [2:0] m, input logic [IW-1:0] p,
                                input logic [IW-1:0] a, input logic [IW-1:0] s,
                                input bit fixed = 1'b0, input result_t fixed_result = '0);
        int gap;
        apply_to_ring(m, p, a, s);
        if (fixed)
            step_results = '{fixed_result};
        foreach (step_results[i])
            due_results = {due_results, step_results[i]};
        if (m <= MODE_SPLIT)
            work_items++;
        commands_sent++;
        gap = tx_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        point <= p;
        anchor <= a;
        stop_point <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Holds the input back until every pending result has come out.
    task automatic await_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    // Fills the ring to capacity, hits the full cases, then cuts it all away.
    task automatic fill_and_cut();
        send_command(MODE_CLEAR, pick_point(0), pick_point(0), pick_point(0));
        while (ring_len < CAP)
            send_command(MODE_APPEND, pick_point(8), pick_point(0), pick_point(0));
        send_command(MODE_APPEND, pick_point(0), pick_point(0), pick_point(0));
        send_command(MODE_INSERT, pick_point(0), pick_point(100), pick_point(0));
        repeat (3)
            send_command(MODE_QUERY, pick_point(80), pick_point(0), pick_point(0));
        send_command(MODE_ERASE, pick_point(100), pick_point(0), pick_point(0));
        send_command(MODE_INSERT, pick_point(0), pick_point(100), pick_point(0));
        await_drain();
        send_command(MODE_SPLIT, pick_point(0), pick_point(100), absent_point());
    endtask

    task automatic mixed_burst(input int n);
        int         roll;
        logic [2:0] m;
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < 28)
                m = MODE_APPEND;
            else if (roll < 46)
                m = MODE_QUERY;
            else if (roll < 60)
                m = MODE_INSERT;
            else if (roll < 74)
                m = MODE_ERASE;
            else if (roll < 88)
                m = MODE_SPLIT;
            else if (roll < 91)
                m = MODE_CLEAR;
            else
                m = 3'($urandom_range(7));
            if (ring_len > 40 && m == MODE_APPEND)
                m = MODE_ERASE;
            if (ring_len < 3 && (m == MODE_SPLIT || m == MODE_ERASE))
                m = MODE_APPEND;
            send_command(m,
                         pick_point((m == MODE_APPEND || m == MODE_INSERT) ? 15 : 80),
                         pick_point(85),
                         ($urandom_range(9) < 8) ? pick_point(90) : pick_point(0));
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                $display("%0t: result with nothing pending, expected none, got status %0d",
                         $time, status);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("status", want.status, status);
                check_field("found", want.found, found);
                check_field("prev_point", want.prev_pt, prev_point);
                check_field("next_point", want.next_pt, next_point);
                check_field("count", want.cnt, count);
                check_field("removed_point", want.gone_pt, removed_point);
                check_field("removed_valid", want.gone_valid, removed_valid);
                check_field("last", want.last_mark, last);
            end
        end
    end

    // Result side back-pressure: mostly short stalls, now and then a long one.
    always @(posedge clk)
    begin
        int roll;
        roll = $urandom_range(99);
        if (rx_hold != 0)
            rx_hold <= rx_hold - 1;
        else if (rx_steady || roll < 60)
        begin
            out_stall <= 1'b0;
            rx_hold <= $urandom_range(3);
        end
        else if (roll < 95)
        begin
            out_stall <= 1'b1;
            rx_hold <= $urandom_range(2);
        end
        else
        begin
            out_stall <= 1'b1;
            rx_hold <= $urandom_range(40, 10);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            dead_cycles <= 0;
        else
            dead_cycles <= dead_cycles + 1;
    end

    initial
    begin
        wait (dead_cycles >= DEAD_LIMIT);
        $display("%0t: no transfer for %0d cycles, %0d results still pending",
                 $time, DEAD_LIMIT, due_results.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        result_t fixed_res;
        int      random_base;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty ring: every lookup misses, spare modes do nothing.
        plan_row(MODE_QUERY, 24'h000000, 24'h000000, 24'h000000, 1, STAT_NOT_FOUND);
        plan_row(MODE_ERASE, 24'h000005, 24'h000000, 24'h000000, 1, STAT_NOT_FOUND);
        plan_row(MODE_SPLIT, 24'h000000, 24'h000000, 24'h000000, 1, STAT_NOT_FOUND);
        plan_row(MODE_INSERT, 24'h000001, 24'h000002, 24'h000000, 1, STAT_NOT_FOUND);
        plan_row(MODE_SPARE_A, 24'h000000, 24'h000000, 24'h000000, 1, STAT_OK);
        plan_row(MODE_SPARE_B, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, STAT_OK);
        // A single entry is its own neighbor on both sides.
        plan_row(MODE_APPEND, 24'hFFFFFF, 24'h000000, 24'h000000, 1, STAT_OK, 0, 0, 0, 1);
        plan_row(MODE_QUERY, 24'hFFFFFF, 24'h000000, 24'h000000, 1, STAT_OK, 1,
                 24'hFFFFFF, 24'hFFFFFF, 1);
        plan_row(MODE_SPLIT, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 1, STAT_OK, 0, 0, 0, 1);
        // Stop point absent: the anchor itself goes too.
        plan_row(MODE_SPLIT, 24'h000000, 24'hFFFFFF, 24'h000123);
        plan_row(MODE_APPEND, 24'h000000, 24'h000000, 24'h000000);
        plan_row(MODE_APPEND, 24'h000001, 24'h000000, 24'h000000);
        plan_row(MODE_APPEND, 24'hAAAAAA, 24'h000000, 24'h000000);
        plan_row(MODE_APPEND, 24'h555555, 24'h000000, 24'h000000);
        plan_row(MODE_APPEND, 24'h800000, 24'h000000, 24'h000000);
        plan_row(MODE_INSERT, 24'h123456, 24'hAAAAAA, 24'h000000);
        plan_row(MODE_INSERT, 24'h000007, 24'h000999, 24'h000000, 1, STAT_NOT_FOUND,
                 0, 0, 0, 6);
        plan_row(MODE_QUERY, 24'h000000, 24'h000000, 24'h000000);
        plan_row(MODE_QUERY, 24'h800000, 24'h000000, 24'h000000);
        plan_row(MODE_ERASE, 24'h555555, 24'h000000, 24'h000000);
        plan_row(MODE_ERASE, 24'h555555, 24'h000000, 24'h000000, 1, STAT_NOT_FOUND,
                 0, 0, 0, 5);
        plan_row(MODE_SPLIT, 24'h000000, 24'h000001, 24'hAAAAAA);
        // This split wraps past the end of the ring.
        plan_row(MODE_SPLIT, 24'h000000, 24'hAAAAAA, 24'h000001);
        // Duplicate entry: searches take the first match.
        plan_row(MODE_APPEND, 24'h000001, 24'h000000, 24'h000000);
        plan_row(MODE_QUERY, 24'h000001, 24'h000000, 24'h000000);
        plan_row(MODE_CLEAR, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1, STAT_OK);

        foreach (plan[i])
        begin
            fixed_res = '0;
            fixed_res.status = plan[i].st;
            fixed_res.found = plan[i].fnd;
            fixed_res.prev_pt = plan[i].pv;
            fixed_res.next_pt = plan[i].nx;
            fixed_res.cnt = plan[i].cnt;
            fixed_res.last_mark = 1'b1;
            send_command(plan[i].m, plan[i].p, plan[i].a, plan[i].s, plan[i].typed,
                         fixed_res);
        end
        await_drain();

        random_base = work_items;
        fill_and_cut();
        while (work_items - random_base < RANDOM_ITEMS)
        begin
            tx_steady = ($urandom_range(4) == 0);
            rx_steady <= ($urandom_range(4) == 0);
            if ($urandom_range(11) == 0)
                fill_and_cut();
            else
                mixed_burst($urandom_range(30, 8));
            if ($urandom_range(3) == 0)
                await_drain();
        end

        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d commands (%0d random list operations), checked %0d results,",
                 commands_sent, work_items - random_base, results_seen);
        $display("%0d entries cut by splits; status ok %0d, missing %0d, full %0d, no stop %0d.",
                 removed_total, status_hits[STAT_OK], status_hits[STAT_NOT_FOUND],
                 status_hits[STAT_FULL], status_hits[STAT_STOP_MISS]);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
